/* src/rational_add_mul_reduce_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef RATIONAL_ADD_MUL_REDUCE_TOP_MACROS_SVH
`define RATIONAL_ADD_MUL_REDUCE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RAMR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define RAMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/ramr_pkg.sv */
// ----------------------------------------------------------------------------
// ramr_pkg
// Types and constants of the rational add/multiply/reduce block.
// ----------------------------------------------------------------------------
`default_nettype none
package ramr_pkg;
    localparam int WORD_BITS_DEF = 64;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_D,
        ST_G1_START,
        ST_G1_WAIT,
        ST_Q1_START,
        ST_Q1_WAIT,
        ST_Q2_START,
        ST_Q2_WAIT,
        ST_MX,
        ST_MY,
        ST_MD,
        ST_SUM,
        ST_G2_START,
        ST_G2_WAIT,
        ST_RN_START,
        ST_RN_WAIT,
        ST_RD_START,
        ST_RD_WAIT,
        ST_OUT
    } state_t;

    // Request to the shared divide/gcd unit.
    typedef struct packed {
        logic start;
        logic is_gcd;
    } du_ctl_t;
endpackage
`default_nettype wire

/* src/ramr_if.sv */
// ----------------------------------------------------------------------------
// ramr_if
// Valid/ready channel carrying a payload.
// ----------------------------------------------------------------------------
`default_nettype none
interface ramr_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rational_add_mul_reduce_top.sv */
// ----------------------------------------------------------------------------
// rational_add_mul_reduce_top
// Adds or multiplies two sign-magnitude fractions and reduces the result.
// ----------------------------------------------------------------------------
// One request at a time. Every product runs on a shift-add multiplier, and
// divides and gcds share one bit-serial divide/gcd unit; a gcd runs one
// divide per Euclid remainder step. A multiply runs two products and one
// gcd, an add three products and two gcds, each plus divides by the gcd.
// The result sits in an output register. The next request is accepted
// while that result waits. A finished result waits in the last state until
// the output register is free.
`default_nettype none
module rational_add_mul_reduce_top
    import ramr_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ramr_if.sink      in_ch,
    ramr_if.source    out_ch
);
    localparam int W   = WORD_BITS;
    localparam int MCW = $clog2(W + 2);

    state_t state_reg, state_next;
    logic          an_reg, bn_reg, neg_reg, ovf_reg;
    logic [W-1:0]  au_reg, ad_reg, bu_reg, bd_reg;
    logic [W-1:0]  g_reg, aq_reg, bq_reg, x_reg, y_reg, rn_reg, rd_reg;
    logic          ovf_next, neg_next;
    logic [W-1:0]  x_next, rn_next, rd_next;
    logic [W-1:0]  ma, mb, sa, sb;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [W:0]    mstep;
    logic [MCW-1:0] mcnt_reg, mcnt_next;
    logic          mul_state, mul_done;
    logic [W:0]    sum;
    logic          ovalid_reg;
    logic          out_load;
    logic [W-1:0]  onum_reg, oden_reg;
    logic          oneg_reg, oovf_reg;
    du_ctl_t       du_ctl;
    logic          du_done;
    logic [W-1:0]  du_a, du_b, du_res;

    ramr_divgcd #(.W(W)) u_du (
        .clk(clk), .rst_n(rst_n), .ctl(du_ctl), .a(du_a), .b(du_b),
        .done(du_done), .res(du_res)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data.result_negative    = oneg_reg;
    assign out_ch.data.result_numerator   = 64'(onum_reg);
    assign out_ch.data.result_denominator = 64'(oden_reg);
    assign out_ch.data.overflow           = oovf_reg;

    // Load the output register once it is empty or being drained.
    assign out_load = (state_reg == ST_OUT) && (!ovalid_reg || out_ch.ready);

    assign sum  = {1'b0, x_reg} + {1'b0, y_reg};

    // Multiplier operand selection.
    always_comb
    begin
        unique case (state_reg)
            ST_MUL_N: begin ma = au_reg; mb = bu_reg; end
            ST_MX:    begin ma = au_reg; mb = bq_reg; end
            ST_MY:    begin ma = bu_reg; mb = aq_reg; end
            default:  begin ma = ad_reg; mb = (state_reg == ST_MD) ? bq_reg : bd_reg; end
        endcase
    end

    // Shift-add multiplier: load mb in the low half, then add ma into the
    // high half and shift right once per multiplier bit.
    assign mul_state = (state_reg == ST_MUL_N) || (state_reg == ST_MUL_D)
                    || (state_reg == ST_MX) || (state_reg == ST_MY)
                    || (state_reg == ST_MD);
    assign mul_done  = (mcnt_reg == MCW'(W + 1));
    assign mstep     = {1'b0, prod_reg[2*W-1:W]}
                     + (prod_reg[0] ? {1'b0, ma} : {(W+1){1'b0}});

    always_comb
    begin
        mcnt_next = '0;
        prod_next = prod_reg;
        if (mul_state && !mul_done)
        begin
            mcnt_next = mcnt_reg + MCW'(1);
            if (mcnt_reg == '0)
                prod_next = {{W{1'b0}}, mb};
            else
                prod_next = {mstep, prod_reg[W-1:1]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_ch.valid && in_ch.ready)
                             state_next = (in_ch.data.operation == OP_MUL) ? ST_MUL_N
                                                                           : ST_G1_START;
            ST_MUL_N:    if (mul_done) state_next = ST_MUL_D;
            ST_MUL_D:    if (mul_done) state_next = ST_G2_START;
            ST_G1_START: state_next = ST_G1_WAIT;
            ST_G1_WAIT:  if (du_done) state_next = ST_Q1_START;
            ST_Q1_START: state_next = ST_Q1_WAIT;
            ST_Q1_WAIT:  if (du_done) state_next = ST_Q2_START;
            ST_Q2_START: state_next = ST_Q2_WAIT;
            ST_Q2_WAIT:  if (du_done) state_next = ST_MX;
            ST_MX:       if (mul_done) state_next = ST_MY;
            ST_MY:       if (mul_done) state_next = ST_MD;
            ST_MD:       if (mul_done) state_next = ST_SUM;
            ST_SUM:      state_next = ST_G2_START;
            ST_G2_START: state_next = ST_G2_WAIT;
            ST_G2_WAIT:  if (du_done) state_next = ST_RN_START;
            ST_RN_START: state_next = ST_RN_WAIT;
            ST_RN_WAIT:  if (du_done) state_next = ST_RD_START;
            ST_RD_START: state_next = ST_RD_WAIT;
            ST_RD_WAIT:  if (du_done) state_next = ST_OUT;
            ST_OUT:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        du_ctl = '0;
        du_a   = '0;
        du_b   = '0;
        unique case (state_reg)
            ST_G1_START: begin du_ctl = '{1'b1, 1'b1}; du_a = ad_reg; du_b = bd_reg; end
            ST_Q1_START: begin du_ctl = '{1'b1, 1'b0}; du_a = bd_reg; du_b = g_reg; end
            ST_Q2_START: begin du_ctl = '{1'b1, 1'b0}; du_a = ad_reg; du_b = g_reg; end
            ST_G2_START: begin du_ctl = '{1'b1, 1'b1}; du_a = rn_reg; du_b = rd_reg; end
            ST_RN_START: begin du_ctl = '{1'b1, 1'b0}; du_a = rn_reg; du_b = g_reg; end
            ST_RD_START: begin du_ctl = '{1'b1, 1'b0}; du_a = rd_reg; du_b = g_reg; end
            default: ;
        endcase
    end

    // Signed combination of the scaled numerators.
    always_comb
    begin
        x_next   = x_reg;
        neg_next = 1'b0;
        ovf_next = ovf_reg;
        priority if (an_reg && bn_reg)
        begin
            x_next = sum[W-1:0]; neg_next = 1'b1; ovf_next = ovf_reg | sum[W];
        end
        else if (an_reg)
        begin
            if (x_reg > y_reg) begin x_next = x_reg - y_reg; neg_next = 1'b1; end
            else x_next = y_reg - x_reg;
        end
        else if (bn_reg)
        begin
            if (x_reg < y_reg) begin x_next = y_reg - x_reg; neg_next = 1'b1; end
            else x_next = x_reg - y_reg;
        end
        else
        begin
            x_next = sum[W-1:0]; ovf_next = ovf_reg | sum[W];
        end
    end

    assign sa = (g_reg == '0) ? rn_reg : du_res;
    assign sb = (g_reg == '0) ? rd_reg : du_res;
    assign rn_next = sa;
    assign rd_next = sb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            mcnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    an_reg <= in_ch.data.first_negative;
                    bn_reg <= in_ch.data.second_negative;
                    au_reg <= in_ch.data.first_numerator[W-1:0];
                    ad_reg <= in_ch.data.first_denominator[W-1:0];
                    bu_reg <= in_ch.data.second_numerator[W-1:0];
                    bd_reg <= in_ch.data.second_denominator[W-1:0];
                    ovf_reg <= 1'b0;
                end
            ST_MUL_N:
                if (mul_done)
                begin
                    rn_reg  <= prod_reg[W-1:0];
                    ovf_reg <= ovf_reg | (prod_reg[2*W-1:W] != '0);
                    neg_reg <= an_reg ^ bn_reg;
                end
            ST_MUL_D, ST_MD:
                if (mul_done)
                begin
                    rd_reg  <= prod_reg[W-1:0];
                    ovf_reg <= ovf_reg | (prod_reg[2*W-1:W] != '0);
                end
            ST_G1_WAIT, ST_G2_WAIT: if (du_done) g_reg <= du_res;
            ST_Q1_WAIT: if (du_done) bq_reg <= du_res;
            ST_Q2_WAIT: if (du_done) aq_reg <= du_res;
            ST_MX:
                if (mul_done)
                begin
                    x_reg   <= prod_reg[W-1:0];
                    ovf_reg <= ovf_reg | (prod_reg[2*W-1:W] != '0);
                end
            ST_MY:
                if (mul_done)
                begin
                    y_reg   <= prod_reg[W-1:0];
                    ovf_reg <= ovf_reg | (prod_reg[2*W-1:W] != '0);
                end
            ST_SUM:
            begin
                rn_reg  <= x_next;
                neg_reg <= neg_next;
                ovf_reg <= ovf_next;
            end
            ST_RN_WAIT: if (du_done) rn_reg <= rn_next;
            ST_RD_WAIT: if (du_done) rd_reg <= rd_next;
            ST_OUT:
                if (out_load)
                begin
                    onum_reg <= rn_reg;
                    oden_reg <= rd_reg;
                    oneg_reg <= neg_reg;
                    oovf_reg <= ovf_reg;
                end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* src/ramr_divgcd.sv */
// ----------------------------------------------------------------------------
// ramr_divgcd
// Shared restoring divider, one quotient bit a cycle; in gcd mode runs the
// Euclidean remainder loop on the same divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ramr_divgcd
    import ramr_pkg::*;
#(
    parameter int W = WORD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire du_ctl_t      ctl,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              done,
    output logic [W-1:0]      res
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          gcd_reg, gcd_next;
    logic          div_reg, div_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          xbig_reg, xbig_next;
    logic          done_reg, done_next;
    logic [W-1:0]  res_reg, res_next;
    logic [W:0]    trial;
    logic [W-1:0]  rsh;

    assign done = done_reg;
    assign res  = res_reg;
    assign rsh  = {r_reg[W-2:0], q_reg[W-1]};
    assign trial = {r_reg, q_reg[W-1]} - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        gcd_next  = gcd_reg;
        div_next  = div_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        xbig_next = xbig_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            gcd_next  = ctl.is_gcd;
            div_next  = 1'b0;
            x_next    = a;
            y_next    = b;
            if (!ctl.is_gcd)
            begin
                // plain quotient a / b
                div_next = 1'b1;
                q_next   = a;
                r_next   = '0;
                d_next   = b;
                cnt_next = CW'(W);
            end
        end
        else if (busy_reg && div_reg)
        begin
            if (!trial[W])
            begin
                r_next = trial[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = rsh;
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                div_next = 1'b0;
                if (gcd_reg)
                begin
                    if (xbig_reg)
                        x_next = trial[W] ? rsh : trial[W-1:0];
                    else
                        y_next = trial[W] ? rsh : trial[W-1:0];
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    res_next  = (d_reg == '0) ? '0
                              : (trial[W] ? {q_reg[W-2:0], 1'b0} : {q_reg[W-2:0], 1'b1});
                end
            end
        end
        else if (busy_reg)
        begin
            // gcd step: finish or launch a remainder
            if (x_reg == '0 || y_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (x_reg == '0) ? y_reg : x_reg;
            end
            else
            begin
                div_next  = 1'b1;
                xbig_next = x_reg > y_reg;
                q_next    = (x_reg > y_reg) ? x_reg : y_reg;
                d_next    = (x_reg > y_reg) ? y_reg : x_reg;
                r_next    = '0;
                cnt_next  = CW'(W);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gcd_reg  <= gcd_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        xbig_reg <= xbig_next;
        res_reg  <= res_next;
    end
endmodule
`default_nettype wire

/* src/ramr_checker.sv */
// ----------------------------------------------------------------------------
// ramr_checker
// Port-level checks of the rational block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_add_mul_reduce_top_macros.svh"
module ramr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [63:0] out_den
);
    `RAMR_ASSERT_IMP(a_known_hs, clk, rst_n, 1'b1, !$isunknown({in_ready, out_valid}), "unknown handshake")
    `RAMR_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after a request")
    `RAMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_den), "result dropped")
    `RAMR_ASSERT_NEXT(a_no_quick, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result too early")
endmodule

bind rational_add_mul_reduce_top ramr_checker u_ramr_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_den(out_ch.data.result_denominator)
);
`default_nettype wire

/* tb/sv/tb_rational_add_mul_reduce_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_add_mul_reduce_top
// Fraction add/multiply checker: directed corner operands, then random
// operand mixes under several sender/receiver idle patterns, each result
// compared field by field against an in-bench fraction calculator.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rational_add_mul_reduce_top;
    import ramr_pkg::*;

    localparam int W = WORD_BITS_DEF;

    typedef struct packed {
        logic         operation;
        logic         first_negative;
        logic [W-1:0] first_numerator;
        logic [W-1:0] first_denominator;
        logic         second_negative;
        logic [W-1:0] second_numerator;
        logic [W-1:0] second_denominator;
    } frac_req_t;

    typedef struct packed {
        logic         result_negative;
        logic [W-1:0] result_numerator;
        logic [W-1:0] result_denominator;
        logic         overflow;
    } frac_res_t;

    logic clk;
    logic rst_n;

    ramr_if #(.payload_t(frac_req_t)) in_ch ();
    ramr_if #(.payload_t(frac_res_t)) out_ch ();

    rational_add_mul_reduce_top #(.WORD_BITS(W)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    frac_res_t pending_fracs[$];
    int        error_count;
    int        idle_pct;
    int        stall_pct;
    bit        wrap_seen;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Fraction calculator
    // ------------------------------------------------------------------
    function automatic logic [W-1:0] mul_w(logic [W-1:0] x, logic [W-1:0] y);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
        if (p[2*W-1:W] != '0)
            wrap_seen = 1'b1;
        return p[W-1:0];
    endfunction

    function automatic logic [W-1:0] add_w(logic [W-1:0] x, logic [W-1:0] y);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s[W])
            wrap_seen = 1'b1;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] euclid(logic [W-1:0] x, logic [W-1:0] y);
        while (x != 0 && y != 0)
        begin
            if (x > y)
                x = x % y;
            else
                y = y % x;
        end
        return (x == 0) ? y : x;
    endfunction

    function automatic frac_res_t calc_fraction(frac_req_t r);
        frac_res_t    res;
        logic [W-1:0] n, d, g, aq, bq, x, y;
        logic         neg;
        wrap_seen = 1'b0;
        if (r.operation == OP_MUL)
        begin
            n   = mul_w(r.first_numerator, r.second_numerator);
            d   = mul_w(r.first_denominator, r.second_denominator);
            neg = r.first_negative != r.second_negative;
        end
        else
        begin
            g   = euclid(r.first_denominator, r.second_denominator);
            bq  = (g == 0) ? '0 : r.second_denominator / g;
            aq  = (g == 0) ? '0 : r.first_denominator / g;
            x   = mul_w(r.first_numerator, bq);
            y   = mul_w(r.second_numerator, aq);
            neg = 1'b0;
            if (r.first_negative && r.second_negative)
            begin
                x   = add_w(x, y);
                neg = 1'b1;
            end
            else if (r.first_negative)
            begin
                neg = x > y;
                x   = (x > y) ? x - y : y - x;
            end
            else if (r.second_negative)
            begin
                neg = x < y;
                x   = (x < y) ? y - x : x - y;
            end
            else
                x = add_w(x, y);
            n = x;
            d = mul_w(r.first_denominator, bq);
        end
        g = euclid(n, d);
        if (g != 0)
        begin
            n = n / g;
            d = d / g;
        end
        res.result_negative    = neg;
        res.result_numerator   = n;
        res.result_denominator = d;
        res.overflow           = wrap_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one request; valid stays high afterwards until a gap or the drain lowers it.
    task automatic send_fraction(frac_req_t r);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_fracs.push_back(calc_fraction(r));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_fracs.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        frac_res_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_fracs.size() == 0)
            begin
                $display("[%0t] result with no request outstanding", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_fracs.pop_front();
                if (out_ch.data.result_negative !== want.result_negative)
                    report_mismatch("sign", W'(out_ch.data.result_negative),
                                    W'(want.result_negative));
                if (out_ch.data.result_numerator !== want.result_numerator)
                    report_mismatch("numerator", out_ch.data.result_numerator,
                                    want.result_numerator);
                if (out_ch.data.result_denominator !== want.result_denominator)
                    report_mismatch("denominator", out_ch.data.result_denominator,
                                    want.result_denominator);
                if (out_ch.data.overflow !== want.overflow)
                    report_mismatch("overflow", W'(out_ch.data.overflow),
                                    W'(want.overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic frac_req_t make_req(logic op, logic an, logic [W-1:0] au,
                                           logic [W-1:0] ad, logic bn,
                                           logic [W-1:0] bu, logic [W-1:0] bd);
        frac_req_t r;
        r = '{op, an, au, ad, bn, bu, bd};
        return r;
    endfunction

    // Mostly short operands keep the gcd loops quick; some go full width.
    function automatic logic [W-1:0] rand_word();
        logic [W-1:0] v;
        int           bits;
        int           pick;
        pick = $urandom_range(99);
        v    = {$urandom, $urandom};
        if (pick < 65)
            bits = $urandom_range(1, 16);
        else if (pick < 88)
            bits = $urandom_range(17, 40);
        else if (pick < 97)
            bits = W;
        else
            return '1;
        return (bits == W) ? v : (v & ((64'd1 << bits) - 1));
    endfunction

    task automatic test_directed();
        logic [W-1:0] mx;
        mx = '1;
        send_fraction(make_req(OP_ADD, 0, 1, 2, 0, 1, 3));
        send_fraction(make_req(OP_MUL, 0, 2, 3, 0, 3, 4));
        // negative zeros
        send_fraction(make_req(OP_ADD, 1, 0, 5, 1, 0, 7));
        send_fraction(make_req(OP_MUL, 1, 0, 5, 0, 9, 7));
        send_fraction(make_req(OP_MUL, 0, 4, 5, 1, 0, 7));
        // both denominators zero on add and multiply
        send_fraction(make_req(OP_ADD, 1, 3, 0, 0, 4, 0));
        send_fraction(make_req(OP_ADD, 0, 0, 0, 0, 0, 0));
        send_fraction(make_req(OP_MUL, 0, 0, 0, 1, 0, 0));
        // sign mixes and equal magnitudes
        send_fraction(make_req(OP_ADD, 1, 3, 4, 0, 3, 4));
        send_fraction(make_req(OP_ADD, 0, 3, 4, 1, 5, 4));
        send_fraction(make_req(OP_ADD, 1, 7, 6, 0, 1, 4));
        send_fraction(make_req(OP_ADD, 0, 7, 6, 1, 1, 4));
        // extremes and wrap
        send_fraction(make_req(OP_MUL, 0, mx, mx, 0, mx, mx));
        send_fraction(make_req(OP_ADD, 0, mx, 1, 0, mx, 1));
        send_fraction(make_req(OP_ADD, 1, mx, mx, 1, 1, mx));
        send_fraction(make_req(OP_MUL, 1, mx, 1, 1, 1, mx));
        send_fraction(make_req(OP_ADD, 0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                               1, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
        send_fraction(make_req(OP_MUL, 0, 64'h8000_0000_0000_0000, 3, 0, 2, 1));
        drain_results();
    endtask

    task automatic test_random(int count, int sender_idle, int receiver_stall);
        frac_req_t r;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count)
        begin
            r.operation          = 1'($urandom_range(1));
            r.first_negative     = 1'($urandom_range(1));
            r.second_negative    = 1'($urandom_range(1));
            r.first_numerator    = rand_word();
            r.second_numerator   = rand_word();
            r.first_denominator  = rand_word();
            r.second_denominator = rand_word();
            if (r.first_denominator == 0)
                r.first_denominator = 1;
            if (r.second_denominator == 0)
                r.second_denominator = 1;
            // shared factors exercise the denominator gcd
            if ($urandom_range(3) == 0)
                r.second_denominator = r.first_denominator * W'($urandom_range(1, 12));
            if (r.second_denominator == 0)
                r.second_denominator = 1;
            send_fraction(r);
        end
        drain_results();
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        error_count  = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(360, 0, 0);
        test_random(360, 61, 0);
        test_random(360, 0, 61);
        test_random(352, 36, 36);

        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("tb_rational_add_mul_reduce_top: done, clean");
        else
            $display("tb_rational_add_mul_reduce_top: done, errors");
        $finish;
    end

    initial
    begin
        #400_000_000;
        $display("[%0t] timeout", $realtime);
        $display("tb_rational_add_mul_reduce_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
+incdir+src
src/ramr_pkg.sv
src/ramr_if.sv
src/ramr_divgcd.sv
src/rational_add_mul_reduce_top.sv
src/ramr_checker.sv
tb/sv/tb_rational_add_mul_reduce_top.sv
